FILE: rtl/mrwc_pkg.sv
// Shared types for the Miller-Rabin witness check block.
`default_nettype none

package mrwc_pkg;

  // Verdict cause codes carried on the result item.
  typedef enum logic [1:0] {
    CAUSE_SMALL_PRIME    = 2'd0,
    CAUSE_TRIVIAL_REJECT = 2'd1,
    CAUSE_PASSED         = 2'd2,
    CAUSE_COMPOSITE      = 2'd3
  } cause_e;

  // Status that the modular multiplier reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

`default_nettype wire

FILE: rtl/mrwc_modmul.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
`default_nettype none

module mrwc_modmul #(
  parameter int NumberWidth = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NumberWidth-1:0]        mcand_i,
  input  logic [((NumberWidth > 31) ? NumberWidth : 31)-1:0] mplier_i,
  input  logic [NumberWidth-1:0]        modulus_i,
  output mrwc_pkg::mm_status_t          status_o,
  output logic [NumberWidth-1:0]        prod_o
);
  import mrwc_pkg::*;

  localparam int NW = NumberWidth;
  localparam int WB = (NW > 31) ? NW : 31;
  localparam int CW = $clog2(WB + 1);

  logic [NW-1:0] acc_q, acc_d;
  logic [NW-1:0] mcand_q;
  logic [WB-1:0] mplier_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [NW+1:0] sum;
  logic [NW+1:0] mod1;
  logic [NW+1:0] mod2;

  // The accumulator stays below the modulus, so 2*acc + mcand is below 3n
  // and at most two subtractions of n bring it back into range.
  always_comb begin
    mod1 = (NW+2)'(modulus_i);
    mod2 = (NW+2)'({modulus_i, 1'b0});
    sum  = (NW+2)'({acc_q, 1'b0}) + (mplier_q[WB-1] ? (NW+2)'(mcand_q) : '0);
    priority if (sum >= mod2) begin
      acc_d = NW'(sum - mod2);
    end else if (sum >= mod1) begin
      acc_d = NW'(sum - mod1);
    end else begin
      acc_d = NW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(WB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mplier_q <= {mplier_q[WB-2:0], 1'b0};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign prod_o        = acc_q;

endmodule

`default_nettype wire

FILE: rtl/miller_rabin_witness_check.sv
// Top level: sequencer for one Miller-Rabin round on a shared modular multiplier.
`default_nettype none

// One item gives a candidate n and a witness base and yields one verdict. Candidates below
// two and even ones above two are rejected without the multiplier, and 2 and 3 are passed
// as small primes the same way. Otherwise every modular product runs on one bit-serial
// multiplier that works through W bits, W being the larger of NUMBER_WIDTH and 31.
// A round needs one product to reduce the witness, NUMBER_WIDTH squarings and
// popcount(d) multiplies for the power, and up to s-1 further squarings, where
// n-1 = d * 2^s. A witness that reduces to zero ends the round early. The input is
// stalled for the whole round; a finished result waits in the output register.
module miller_rabin_witness_check #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [30:0] candidate_i,
  input  logic [30:0] witness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        probable_prime_o,
  output logic [1:0]  verdict_cause_o
);
  import mrwc_pkg::*;

  localparam int NW = NUMBER_WIDTH;
  localparam int WB = (NW > 31) ? NW : 31;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_RED_WAIT,
    ST_POW_NEXT,
    ST_SQ_WAIT,
    ST_POW_MUL,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_LOOP,
    ST_LOOP_WAIT,
    ST_RESULT
  } state_e;

  state_e        state_q;
  logic [NW-1:0] n_q;
  logic [30:0]   w_q;
  logic [NW-1:0] d_q;
  logic [NW-1:0] a_q;
  logic [NW-1:0] x_q;
  logic [CW-1:0] s_q;
  logic [CW-1:0] cnt_q;
  logic          pass_q;
  cause_e        cause_q;
  logic          out_valid_q;
  logic          out_prime_q;
  cause_e        out_cause_q;

  logic [NW-1:0] n_in;
  logic [NW-1:0] nm1;
  logic          is_reject;
  logic          is_small;

  logic          mm_start;
  logic [NW-1:0] mm_mcand;
  logic [WB-1:0] mm_mplier;
  mm_status_t    mm_stat;
  logic [NW-1:0] mm_prod;

  assign n_in      = NW'({1'b0, candidate_i});
  assign is_reject = (n_in < NW'(2)) || ((n_in > NW'(3)) && !n_in[0]);
  assign is_small  = (n_in == NW'(2)) || (n_in == NW'(3));
  assign nm1       = n_q - NW'(1);

  // Operand selection for the shared multiplier; squaring is the usual case.
  always_comb begin
    mm_start  = 1'b0;
    mm_mcand  = x_q;
    mm_mplier = WB'(x_q);
    unique case (state_q)
      ST_SPLIT: begin
        // Reducing the witness is a product with one.
        if (d_q[0]) begin
          mm_start  = 1'b1;
          mm_mcand  = NW'(1);
          mm_mplier = WB'(w_q);
        end
      end
      ST_POW_NEXT: mm_start = (cnt_q != '0);
      ST_POW_MUL: begin
        mm_start  = 1'b1;
        mm_mplier = WB'(a_q);
      end
      ST_LOOP: mm_start = (s_q > CW'(1));
      default: mm_start = 1'b0;
    endcase
  end

  mrwc_modmul #(
    .NumberWidth(NW)
  ) u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .mcand_i  (mm_mcand),
    .mplier_i (mm_mplier),
    .modulus_i(n_q),
    .status_o (mm_stat),
    .prod_o   (mm_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      w_q         <= '0;
      d_q         <= '0;
      a_q         <= '0;
      x_q         <= '0;
      s_q         <= '0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      cause_q     <= CAUSE_SMALL_PRIME;
      out_valid_q <= 1'b0;
      out_prime_q <= 1'b0;
      out_cause_q <= CAUSE_SMALL_PRIME;
    end else begin
      // A result that leaves while the next one is loaded is handled in ST_RESULT.
      if (out_valid_q && !out_stall_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q <= n_in;
            w_q <= witness_i;
            d_q <= n_in - NW'(1);
            s_q <= '0;
            priority if (is_reject) begin
              pass_q  <= 1'b0;
              cause_q <= CAUSE_TRIVIAL_REJECT;
              state_q <= ST_RESULT;
            end else if (is_small) begin
              pass_q  <= 1'b1;
              cause_q <= CAUSE_SMALL_PRIME;
              state_q <= ST_RESULT;
            end else begin
              state_q <= ST_SPLIT;
            end
          end
        end
        ST_SPLIT: begin
          if (d_q[0]) begin
            state_q <= ST_RED_WAIT;
          end else begin
            d_q <= {1'b0, d_q[NW-1:1]};
            s_q <= s_q + CW'(1);
          end
        end
        ST_RED_WAIT: begin
          if (mm_stat.done) begin
            a_q   <= mm_prod;
            x_q   <= NW'(1);
            cnt_q <= CW'(NW);
            if (mm_prod == '0) begin
              // A witness that reduces to zero gives no evidence; the round counts as passed.
              pass_q  <= 1'b1;
              cause_q <= CAUSE_PASSED;
              state_q <= ST_RESULT;
            end else begin
              state_q <= ST_POW_NEXT;
            end
          end
        end
        ST_POW_NEXT: begin
          // Left-to-right exponentiation over every bit of d, leading zeros too.
          state_q <= (cnt_q != '0) ? ST_SQ_WAIT : ST_CHECK;
        end
        ST_SQ_WAIT: begin
          if (mm_stat.done) begin
            x_q <= mm_prod;
            if (d_q[NW-1]) begin
              state_q <= ST_POW_MUL;
            end else begin
              d_q     <= {d_q[NW-2:0], 1'b0};
              cnt_q   <= cnt_q - CW'(1);
              state_q <= ST_POW_NEXT;
            end
          end
        end
        ST_POW_MUL: begin
          state_q <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mm_stat.done) begin
            x_q     <= mm_prod;
            d_q     <= {d_q[NW-2:0], 1'b0};
            cnt_q   <= cnt_q - CW'(1);
            state_q <= ST_POW_NEXT;
          end
        end
        ST_CHECK: begin
          if ((x_q == NW'(1)) || (x_q == nm1)) begin
            pass_q  <= 1'b1;
            cause_q <= CAUSE_PASSED;
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (s_q > CW'(1)) begin
            s_q     <= s_q - CW'(1);
            state_q <= ST_LOOP_WAIT;
          end else begin
            pass_q  <= 1'b0;
            cause_q <= CAUSE_COMPOSITE;
            state_q <= ST_RESULT;
          end
        end
        ST_LOOP_WAIT: begin
          if (mm_stat.done) begin
            x_q <= mm_prod;
            if (mm_prod == nm1) begin
              pass_q  <= 1'b1;
              cause_q <= CAUSE_PASSED;
              state_q <= ST_RESULT;
            end else begin
              state_q <= ST_LOOP;
            end
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_prime_q <= pass_q;
            out_cause_q <= cause_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign probable_prime_o = out_prime_q;
  assign verdict_cause_o  = out_cause_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_stat.done |-> (state_q == ST_RED_WAIT || state_q == ST_SQ_WAIT ||
                      state_q == ST_MUL_WAIT || state_q == ST_LOOP_WAIT))
    else $error("multiplier finished outside a wait state");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result raised without a finished round");

endmodule

`default_nettype wire
